// ===== src/ssvh_pkg.sv =====
// shared types, constants and register codes of the spectral snr voice activity detector
package ssvh_pkg;

  // default sample width of the real and imaginary bin parts
  localparam int unsigned SampleBitsDef = 16;

  // fixed field and state widths
  localparam int unsigned NoiseW   = 32;
  localparam int unsigned AccW     = 42;
  localparam int unsigned BinW     = 11;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned HangW    = 8;
  localparam int unsigned RunW     = 7;
  localparam int unsigned ProdW    = AccW + RatioW;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned OutDataW = 8;

  // saturation limits
  localparam logic [AccW-1:0] SumMax    = {AccW{1'b1}};
  localparam logic [BinW-1:0] BinCntMax = {BinW{1'b1}};
  localparam logic [RunW-1:0] RunMax    = {RunW{1'b1}};

  // bit positions in the result beat
  localparam int unsigned OutNoiseOnlyBit  = 0;
  localparam int unsigned OutVoiceBit      = 1;
  localparam int unsigned OutInstSpeechBit = 2;
  localparam int unsigned OutRunReadyBit   = 3;

  // configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    RegSpeechLow   = 3'd0,
    RegSpeechHigh  = 3'd1,
    RegNoiseRatio  = 3'd2,
    RegSpeechRatio = 3'd3,
    RegHangFrames  = 3'd4,
    RegVadEnable   = 3'd5,
    RegNoiseFrames = 3'd6
  } reg_idx_e;

  // configuration register contents
  typedef struct packed {
    logic [BinW-1:0]   speech_bin_low;
    logic [BinW-1:0]   speech_bin_high;
    logic [RatioW-1:0] noise_ratio;
    logic [RatioW-1:0] speech_ratio;
    logic [HangW-1:0]  hangover_frames;
    logic              vad_enable;
    logic [RunW-1:0]   noise_frames_needed;
  } cfg_t;

  // per-bin side information next to the bin power
  typedef struct packed {
    logic in_band;
    logic last;
  } bin_ctl_t;

  // band sums of one finished frame
  typedef struct packed {
    logic [AccW-1:0] tot_obs;
    logic [AccW-1:0] tot_noi;
    logic [AccW-1:0] sp_obs;
    logic [AccW-1:0] sp_noi;
  } frame_sums_t;

endpackage

// ===== src/spectral_snr_vad_hangover_unit.sv =====
// top level of the spectral snr voice activity detector with hangover
//
// Input stream: one spectrum bin per beat, bins 1 to N/2 of a frame in order.
//   tdata holds bin_real, bin_imag (SampleBits each, signed) and noise_power
//   (32 bits); tlast marks the last bin of the frame.
// Output stream: one beat per frame, issued only for the bin that carried tlast,
//   with noise_only, voice_active, instant_speech and noise_run_ready.
// Configuration: plain write port, register index and data, taken on any edge
//   with cfg_we_i high; write it only while no frame is in flight.
// Throughput: one bin per cycle while the output accepts. The path is input
//   register, square and add, saturating accumulate, threshold multiply, compare and counter update.
// Result path: power, snapshot and product registers, then the result register.
// Reset: sums clear, bin index returns to one, hangover and noise run counters
//   clear, registers take their defaults, both streams idle.
// Output stall: the result register holds its beat; bins keep flowing into the
//   accumulators, two more frame results queue in the snapshot and product
//   stages, and the input stalls only when a fourth frame end reaches the
//   accumulators while the first result is still waiting.
module spectral_snr_vad_hangover_unit #(
  parameter int unsigned SampleBits = ssvh_pkg::SampleBitsDef,
  localparam int unsigned InDataW =
    ((2 * SampleBits + ssvh_pkg::NoiseW + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssvh_pkg::RegIdxW-1:0]     cfg_addr_i,
  input  logic [ssvh_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // bin_real, bin_imag, noise_power, zero fill
  input  logic [InDataW-1:0]               s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // noise_only, voice_active, instant_speech, noise_run_ready, zero fill
  output logic [ssvh_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import ssvh_pkg::*;

  localparam int unsigned PowW = 2 * SampleBits;

  cfg_t              cfg;
  logic              pw_valid, pw_ready;
  logic [PowW-1:0]   pw_power;
  logic [NoiseW-1:0] pw_noise;
  bin_ctl_t          pw_ctl;
  logic              sum_valid, sum_ready;
  frame_sums_t       sums;

  // configuration registers
  ssvh_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // per-bin power
  ssvh_bin_power #(
    .SampleBits(SampleBits)
  ) u_bin_power (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .s_last_i  (s_axis_tlast_i),
    .pw_valid_o(pw_valid),
    .pw_ready_i(pw_ready),
    .pw_power_o(pw_power),
    .pw_noise_o(pw_noise),
    .pw_ctl_o  (pw_ctl)
  );

  // band accumulation
  ssvh_accum #(
    .SampleBits(SampleBits)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pw_valid_i (pw_valid),
    .pw_ready_o (pw_ready),
    .pw_power_i (pw_power),
    .pw_noise_i (pw_noise),
    .pw_ctl_i   (pw_ctl),
    .sum_valid_o(sum_valid),
    .sum_ready_i(sum_ready),
    .sums_o     (sums)
  );

  // frame decision
  ssvh_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .sum_valid_i(sum_valid),
    .sum_ready_o(sum_ready),
    .sums_i     (sums),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_data_o (m_axis_tdata_o)
  );

endmodule

// ===== src/ssvh_cfg_regs.sv =====
// configuration register file of the spectral snr voice activity detector
module ssvh_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssvh_pkg::RegIdxW-1:0]     cfg_addr_i,
  input  logic [ssvh_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output ssvh_pkg::cfg_t                   cfg_o
);
  import ssvh_pkg::*;

  cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speech_bin_low      <= BinW'(0);
      cfg_q.speech_bin_high     <= BinW'(1024);
      cfg_q.noise_ratio         <= RatioW'(256);
      cfg_q.speech_ratio        <= RatioW'(512);
      cfg_q.hangover_frames     <= HangW'(16);
      cfg_q.vad_enable          <= 1'b1;
      cfg_q.noise_frames_needed <= RunW'(8);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        RegSpeechLow:   cfg_q.speech_bin_low      <= cfg_wdata_i[BinW-1:0];
        RegSpeechHigh:  cfg_q.speech_bin_high     <= cfg_wdata_i[BinW-1:0];
        RegNoiseRatio:  cfg_q.noise_ratio         <= cfg_wdata_i[RatioW-1:0];
        RegSpeechRatio: cfg_q.speech_ratio        <= cfg_wdata_i[RatioW-1:0];
        RegHangFrames:  cfg_q.hangover_frames     <= cfg_wdata_i[HangW-1:0];
        RegVadEnable:   cfg_q.vad_enable          <= cfg_wdata_i[0];
        RegNoiseFrames: cfg_q.noise_frames_needed <= cfg_wdata_i[RunW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ssvh_bin_power.sv =====
// input register, bin power squaring, noise floor and speech band tagging
module ssvh_bin_power #(
  parameter int unsigned SampleBits = ssvh_pkg::SampleBitsDef,
  localparam int unsigned InDataW =
    ((2 * SampleBits + ssvh_pkg::NoiseW + 7) / 8) * 8,
  localparam int unsigned PowW = 2 * SampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssvh_pkg::cfg_t                cfg_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [InDataW-1:0]            s_data_i,
  input  logic                          s_last_i,
  output logic                          pw_valid_o,
  input  logic                          pw_ready_i,
  output logic [PowW-1:0]               pw_power_o,
  output logic [ssvh_pkg::NoiseW-1:0]   pw_noise_o,
  output ssvh_pkg::bin_ctl_t            pw_ctl_o
);
  import ssvh_pkg::*;

  logic                  in_valid_q;
  logic [SampleBits-1:0] re_q, im_q;
  logic [NoiseW-1:0]     noise_q;
  logic                  last_q;

  logic                  pw_valid_q;
  logic [PowW-1:0]       pow_q;
  logic [NoiseW-1:0]     noi_q;
  bin_ctl_t              ctl_q;

  logic [BinW-1:0]       bin_cnt_q, bin_cnt_d;

  logic                  pw_free, in_move, in_fire;
  logic [SampleBits-1:0] re_mag, im_mag;
  logic [PowW-1:0]       re_sq, im_sq, pow_d;
  logic [NoiseW-1:0]     noi_d;
  logic                  in_band;

  // stage handshakes
  assign pw_free   = !pw_valid_q || pw_ready_i;
  assign in_move   = in_valid_q && pw_free;
  assign s_ready_o = !in_valid_q || pw_free;
  assign in_fire   = s_valid_i && s_ready_o;

  // magnitude, squares and floored noise
  always_comb begin
    re_mag  = re_q[SampleBits-1] ? (~re_q + SampleBits'(1)) : re_q;
    im_mag  = im_q[SampleBits-1] ? (~im_q + SampleBits'(1)) : im_q;
    re_sq   = PowW'(re_mag) * PowW'(re_mag);
    im_sq   = PowW'(im_mag) * PowW'(im_mag);
    pow_d   = re_sq + im_sq;
    noi_d   = (noise_q == '0) ? NoiseW'(1) : noise_q;
    in_band = (bin_cnt_q >= cfg_i.speech_bin_low) && (bin_cnt_q <= cfg_i.speech_bin_high);
  end

  // bin index of the next bin, back to one after the last bin
  always_comb begin
    bin_cnt_d = bin_cnt_q;
    if (in_move) begin
      if (last_q) begin
        bin_cnt_d = BinW'(1);
      end else if (bin_cnt_q != BinCntMax) begin
        bin_cnt_d = bin_cnt_q + BinW'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pw_valid_q <= 1'b0;
      bin_cnt_q  <= BinW'(1);
    end else begin
      if (s_ready_o) begin
        in_valid_q <= s_valid_i;
      end
      if (pw_free) begin
        pw_valid_q <= in_valid_q;
      end
      bin_cnt_q <= bin_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      re_q    <= s_data_i[SampleBits-1:0];
      im_q    <= s_data_i[2*SampleBits-1:SampleBits];
      noise_q <= s_data_i[2*SampleBits+NoiseW-1:2*SampleBits];
      last_q  <= s_last_i;
    end
    if (in_move) begin
      pow_q         <= pow_d;
      noi_q         <= noi_d;
      ctl_q.in_band <= in_band;
      ctl_q.last    <= last_q;
    end
  end

  assign pw_valid_o = pw_valid_q;
  assign pw_power_o = pow_q;
  assign pw_noise_o = noi_q;
  assign pw_ctl_o   = ctl_q;

  // bin index never reaches zero
  a_bin_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_cnt_q != '0)
    else $error("bin counter reached zero");

endmodule

// ===== src/ssvh_accum.sv =====
// saturating band power accumulators and end-of-frame snapshot
module ssvh_accum #(
  parameter int unsigned SampleBits = ssvh_pkg::SampleBitsDef,
  localparam int unsigned PowW = 2 * SampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pw_valid_i,
  output logic                          pw_ready_o,
  input  logic [PowW-1:0]               pw_power_i,
  input  logic [ssvh_pkg::NoiseW-1:0]   pw_noise_i,
  input  ssvh_pkg::bin_ctl_t            pw_ctl_i,
  output logic                          sum_valid_o,
  input  logic                          sum_ready_i,
  output ssvh_pkg::frame_sums_t         sums_o
);
  import ssvh_pkg::*;

  localparam int unsigned ExtW = ((PowW > AccW) ? PowW : AccW) + 1;

  logic [AccW-1:0] tot_obs_q, tot_noi_q, sp_obs_q, sp_noi_q;
  logic [AccW-1:0] tot_obs_d, tot_noi_d, sp_obs_d, sp_noi_d;
  logic            sum_valid_q, sum_valid_d;
  frame_sums_t     sums_q;
  logic            consume, frame_end;

  // add with saturation at the top of the accumulator range
  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [ExtW-1:0] b);
    logic [ExtW-1:0] s;
    s = ExtW'(a) + b;
    return (s > ExtW'(SumMax)) ? SumMax : s[AccW-1:0];
  endfunction

  assign pw_ready_o = !pw_ctl_i.last || !sum_valid_q || sum_ready_i;
  assign consume    = pw_valid_i && pw_ready_o;
  assign frame_end  = consume && pw_ctl_i.last;

  // updated band sums including the current bin
  always_comb begin
    tot_obs_d = sat_add(tot_obs_q, ExtW'(pw_power_i));
    tot_noi_d = sat_add(tot_noi_q, ExtW'(pw_noise_i));
    sp_obs_d  = sp_obs_q;
    sp_noi_d  = sp_noi_q;
    if (pw_ctl_i.in_band) begin
      sp_obs_d = sat_add(sp_obs_q, ExtW'(pw_power_i));
      sp_noi_d = sat_add(sp_noi_q, ExtW'(pw_noise_i));
    end
  end

  assign sum_valid_d = (sum_valid_q && !sum_ready_i) || frame_end;

  // accumulators, cleared after the last bin of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_obs_q   <= '0;
      tot_noi_q   <= '0;
      sp_obs_q    <= '0;
      sp_noi_q    <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= sum_valid_d;
      if (consume) begin
        if (pw_ctl_i.last) begin
          tot_obs_q <= '0;
          tot_noi_q <= '0;
          sp_obs_q  <= '0;
          sp_noi_q  <= '0;
        end else begin
          tot_obs_q <= tot_obs_d;
          tot_noi_q <= tot_noi_d;
          sp_obs_q  <= sp_obs_d;
          sp_noi_q  <= sp_noi_d;
        end
      end
    end
  end

  // frame snapshot, empty speech band noise floored at one
  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      sums_q.tot_obs <= tot_obs_d;
      sums_q.tot_noi <= tot_noi_d;
      sums_q.sp_obs  <= sp_obs_d;
      sums_q.sp_noi  <= (sp_noi_d == '0) ? AccW'(1) : sp_noi_d;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sums_o      = sums_q;

  // speech band is a subset of the whole band
  a_band_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_noi_q <= tot_noi_q) && (sp_obs_q <= tot_obs_q))
    else $error("speech band sum exceeds total sum");

  // sums start from zero after the frame end
  a_clear_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> (tot_noi_q == '0) && (sp_obs_q == '0))
    else $error("accumulators not cleared after last bin");

endmodule

// ===== src/ssvh_decide.sv =====
// threshold products, snr decisions, hangover and noise run counters, result register
module ssvh_decide (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ssvh_pkg::cfg_t                   cfg_i,
  input  logic                             sum_valid_i,
  output logic                             sum_ready_o,
  input  ssvh_pkg::frame_sums_t            sums_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [ssvh_pkg::OutDataW-1:0]    res_data_o
);
  import ssvh_pkg::*;

  logic             prd_valid_q;
  logic [ProdW-1:0] sp_nr_q, sp_sr_q, tot_nr_q;
  logic [AccW-1:0]  sp_obs_q, tot_obs_q;

  logic [HangW-1:0] hang_q, hang_d;
  logic [RunW-1:0]  run_q, run_d;

  logic                res_valid_q;
  logic [OutDataW-1:0] res_q, res_d;

  logic             out_free, prd_move, sum_fire;
  logic [ProdW-1:0] sp_scaled, tot_scaled;
  logic             noise_only, speech, voice, run_ready;

  // stage handshakes
  assign out_free    = !res_valid_q || res_ready_i;
  assign prd_move    = prd_valid_q && out_free;
  assign sum_ready_o = !prd_valid_q || out_free;
  assign sum_fire    = sum_valid_i && sum_ready_o;

  // snr compares, observed*256 against noise*ratio
  always_comb begin
    sp_scaled  = ProdW'({sp_obs_q, 8'd0});
    tot_scaled = ProdW'({tot_obs_q, 8'd0});
    noise_only = (sp_scaled < sp_nr_q) && (tot_scaled < tot_nr_q);
    speech     = cfg_i.vad_enable && (sp_scaled > sp_sr_q) && (tot_scaled > tot_nr_q);
  end

  // hangover and noise run counters
  always_comb begin
    hang_d = hang_q;
    voice  = 1'b0;
    if (cfg_i.vad_enable) begin
      if (speech) begin
        voice  = 1'b1;
        hang_d = cfg_i.hangover_frames;
      end else if (hang_q != '0) begin
        voice  = 1'b1;
        hang_d = hang_q - HangW'(1);
      end
    end
    if (noise_only) begin
      run_d = (run_q == RunMax) ? run_q : run_q + RunW'(1);
    end else begin
      run_d = '0;
    end
    run_ready = run_d >= cfg_i.noise_frames_needed;
    res_d                   = '0;
    res_d[OutNoiseOnlyBit]  = noise_only;
    res_d[OutVoiceBit]      = voice;
    res_d[OutInstSpeechBit] = speech;
    res_d[OutRunReadyBit]   = run_ready;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      hang_q      <= '0;
      run_q       <= '0;
    end else begin
      if (sum_ready_o) begin
        prd_valid_q <= sum_valid_i;
      end
      if (out_free) begin
        res_valid_q <= prd_valid_q;
      end
      if (prd_move) begin
        hang_q <= hang_d;
        run_q  <= run_d;
      end
    end
  end

  // threshold products and result payload
  always_ff @(posedge clk_i) begin
    if (sum_fire) begin
      sp_nr_q   <= ProdW'(sums_i.sp_noi) * ProdW'(cfg_i.noise_ratio);
      sp_sr_q   <= ProdW'(sums_i.sp_noi) * ProdW'(cfg_i.speech_ratio);
      tot_nr_q  <= ProdW'(sums_i.tot_noi) * ProdW'(cfg_i.noise_ratio);
      sp_obs_q  <= sums_i.sp_obs;
      tot_obs_q <= sums_i.tot_obs;
    end
    if (prd_move) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_q;

  // noise-only and instant speech exclude each other on the total band
  a_noise_speech_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q[OutNoiseOnlyBit] && res_q[OutInstSpeechBit]))
    else $error("noise-only and instant speech both set");

  // instant speech always raises the voice flag
  a_speech_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q[OutInstSpeechBit]) |-> res_q[OutVoiceBit])
    else $error("instant speech without voice flag");

endmodule
